// ===== src/ymodem_frame_receiver_macros.svh =====
// Assertion macros for the YMODEM frame receiver RTL.
`ifndef YMODEM_FRAME_RECEIVER_MACROS_SVH
`define YMODEM_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define YMFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ymfr check failed");
// Next-cycle implication, disabled during reset.
`define YMFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ymfr check failed");
`else
`define YMFR_ASSERT_NOW(lbl, ante, cons)
`define YMFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/ymfr_pkg.sv =====
// Shared types and protocol constants for the YMODEM frame receiver.
`default_nettype none
package ymfr_pkg;

  // YMODEM control characters
  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [7:0] CODE_C   = 8'h43;

  // Result actions
  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_ERASE = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_DONE  = 2'd3;

  // Item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] REG_APP_BASE  = 8'd0;
  localparam logic [7:0] REG_ERASE_CNT = 8'd1;
  localparam logic [7:0] REG_TIMEOUT   = 8'd2;
  localparam logic [7:0] REG_END_BYTE  = 8'd3;

  localparam int unsigned SMALL_BLOCK = 128;
  localparam int unsigned LARGE_BLOCK = 1024;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  // Settings used by the protocol engine
  typedef struct packed {
    logic [31:0] app_base_address;
    logic [7:0]  erase_sector_count;
    logic [7:0]  end_response_byte;
  } ymfr_cfg_t;

  // Closed frame handed from the front end to the queue
  typedef struct packed {
    logic       push;
    logic [7:0] first_byte;
  } ymfr_frame_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic       full;
    logic       empty;
    logic [7:0] head_byte;
  } ymfr_qstat_t;

endpackage
`default_nettype wire

// ===== src/ymfr_if.sv =====
// Valid/ready channel interfaces of the YMODEM frame receiver.
`default_nettype none

interface ymfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface ymfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  response_byte;
  logic [31:0] flash_address;
  logic [10:0] amount;
  logic        last;
  modport source (output valid, output action, output response_byte,
                  output flash_address, output amount, output last, input ready);
  modport sink (input valid, input action, input response_byte,
                input flash_address, input amount, input last, output ready);
endinterface

interface ymfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/ymfr_front.sv =====
// Frame assembly: counts bytes, runs the idle gap timer, closes frames.
`default_nettype none
module ymfr_front import ymfr_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ymfr_in_if.sink          item,
  input  wire logic [15:0] idle_timeout_ticks,
  input  wire ymfr_qstat_t qstat,
  output ymfr_frame_t      frame
);

  localparam int unsigned LEN_W = $clog2(FRAME_CAPACITY + 1);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(FRAME_CAPACITY);

  logic [7:0]       first_byte;
  logic [LEN_W-1:0] frame_length;
  logic [15:0]      idle_ticks;
  logic             running;
  logic [15:0]      idle_inc;
  logic             accept;
  logic             closing;

  assign item.ready = !qstat.full;
  assign accept     = item.valid && item.ready;
  assign idle_inc   = (idle_ticks < IDLE_MAX) ? idle_ticks + 16'd1 : idle_ticks;
  assign closing    = accept && (item.mode == MODE_TICK) && running &&
                      (idle_inc >= idle_timeout_ticks);

  assign frame.push       = closing && (frame_length != '0);
  assign frame.first_byte = first_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      idle_ticks   <= '0;
      running      <= 1'b0;
    end else if (accept) begin
      if (item.mode == MODE_BYTE) begin
        if (frame_length < CAP) begin
          frame_length <= frame_length + LEN_W'(1);
        end
        idle_ticks <= '0;
        running    <= 1'b1;
      end else if (running) begin
        if (closing) begin
          running      <= 1'b0;
          idle_ticks   <= '0;
          frame_length <= '0;
        end else begin
          idle_ticks <= idle_inc;
        end
      end
    end
  end

  // First byte of a frame: only read while the frame length is nonzero
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_BYTE && frame_length == '0) begin
      first_byte <= item.rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/ymfr_queue.sv =====
// Short queue of closed frames between the front end and the protocol engine.
`default_nettype none
module ymfr_queue import ymfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ymfr_frame_t frame,
  input  wire logic        pop,
  output ymfr_qstat_t      qstat
);

  logic [7:0]          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign qstat.full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat.empty     = (count == '0);
  assign qstat.head_byte = slots[rd_ptr];

  assign do_push = frame.push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= frame.first_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/ymfr_back.sv =====
// Protocol engine: YMODEM phases, one result per clock unless stalled.
`default_nettype none
`include "ymodem_frame_receiver_macros.svh"
module ymfr_back import ymfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ymfr_cfg_t   cfg,
  input  wire ymfr_qstat_t qstat,
  output logic             pop,
  ymfr_out_if.source       result
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_EOT2  = 2'd2;
  localparam logic [1:0] PH_CLOSE = 2'd3;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [31:0] write_address;
  logic [31:0] write_address_next;
  logic [1:0]  step;

  logic        emit;
  logic [1:0]  r_action;
  logic [7:0]  r_byte;
  logic [31:0] r_addr;
  logic [10:0] r_amount;
  logic        r_last;
  logic        slot_free;
  logic        go;
  logic        done;
  logic [7:0]  head;
  logic [10:0] blk_size;

  logic        ovalid;
  logic [1:0]  o_action;
  logic [7:0]  o_byte;
  logic [31:0] o_addr;
  logic [10:0] o_amount;
  logic        o_last;

  assign head      = qstat.head_byte;
  assign slot_free = !ovalid || result.ready;
  assign go        = !qstat.empty && slot_free;
  assign done      = r_last || !emit;
  assign pop       = go && done;
  assign blk_size  = (head == CODE_SOH) ? 11'(SMALL_BLOCK) : 11'(LARGE_BLOCK);

  // Result number "step" of the frame at the queue head
  always_comb begin
    emit               = 1'b0;
    r_action           = ACT_SEND;
    r_byte             = 8'h00;
    r_addr             = 32'h0;
    r_amount           = 11'd0;
    r_last             = 1'b0;
    phase_next         = phase;
    write_address_next = write_address;
    case (phase)
      PH_START: begin
        if (head == CODE_SOH) begin
          emit = 1'b1;
          case (step)
            2'd0: begin
              r_action           = ACT_ERASE;
              r_addr             = cfg.app_base_address;
              r_amount           = {3'b000, cfg.erase_sector_count};
              write_address_next = cfg.app_base_address;
            end
            2'd1: r_byte = CODE_ACK;
            default: begin
              r_byte     = CODE_C;
              r_last     = 1'b1;
              phase_next = PH_DATA;
            end
          endcase
        end
      end
      PH_DATA: begin
        if (head == CODE_SOH || head == CODE_STX) begin
          emit = 1'b1;
          if (step == 2'd0) begin
            r_action           = ACT_WRITE;
            r_addr             = write_address;
            r_amount           = blk_size;
            write_address_next = write_address + {21'd0, blk_size};
          end else begin
            r_byte = CODE_ACK;
            r_last = 1'b1;
          end
        end else if (head == CODE_EOT) begin
          emit       = 1'b1;
          r_byte     = CODE_NAK;
          r_last     = 1'b1;
          phase_next = PH_EOT2;
        end else begin
          // drop the frame and fall back to waiting for a start frame
          phase_next = PH_START;
        end
      end
      PH_EOT2: begin
        if (head == CODE_EOT) begin
          emit = 1'b1;
          if (step == 2'd0) begin
            r_byte = CODE_ACK;
          end else begin
            r_byte     = CODE_C;
            r_last     = 1'b1;
            phase_next = PH_CLOSE;
          end
        end
      end
      default: begin
        if (head == CODE_SOH) begin
          emit = 1'b1;
          case (step)
            2'd0: r_byte = CODE_ACK;
            2'd1: r_byte = cfg.end_response_byte;
            default: begin
              r_action   = ACT_DONE;
              r_last     = 1'b1;
              phase_next = PH_START;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      write_address <= 32'h0;
      step          <= 2'd0;
      ovalid        <= 1'b0;
    end else begin
      if (go) begin
        write_address <= write_address_next;
        if (done) begin
          phase <= phase_next;
          step  <= 2'd0;
        end else begin
          step <= step + 2'd1;
        end
      end
      if (go && emit) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      o_action <= r_action;
      o_byte   <= r_byte;
      o_addr   <= r_addr;
      o_amount <= r_amount;
      o_last   <= r_last;
    end
  end

  assign result.valid         = ovalid;
  assign result.action        = o_action;
  assign result.response_byte = o_byte;
  assign result.flash_address = o_addr;
  assign result.amount        = o_amount;
  assign result.last          = o_last;

  `YMFR_ASSERT_NOW(a_step_range, 1'b1, step != 2'd3)
  `YMFR_ASSERT_NEXT(a_phase_only_on_pop, !pop, phase == $past(phase))
  `YMFR_ASSERT_NEXT(a_step_clear_after_pop, pop, step == 2'd0)
  `YMFR_ASSERT_NOW(a_no_emit_when_blocked, go && emit, slot_free && !qstat.empty)

endmodule
`default_nettype wire

// ===== src/ymodem_frame_receiver.sv =====
// Top level of the YMODEM frame receiver: config registers and block wiring.
`default_nettype none
// The receiver takes one item per clock on the item channel: a UART byte
// (mode 0) or a time tick (mode 1). Bytes build up a frame of which only the
// first byte and a length saturating at FRAME_CAPACITY are kept; a frame
// closes on the tick that brings the idle count since its last byte up to
// idle_timeout_ticks. Closed frames go into a four-entry queue and the
// protocol engine turns each one into zero to three results (erase, block
// write, response bytes, done mark), one result per clock, through a
// registered output stage; the last result of a frame has last set. The
// item channel takes a transfer every clock as long as the frame queue has
// room. It stalls when the queue fills: either the result side is held off,
// or frames close faster than the engine can emit their results (a frame can
// close every second item at a zero timeout and cause up to three results,
// while the engine emits one result per clock). With the queue and the
// output stage free, the frame closed by a tick is queued and the engine
// then registers its first result in the output stage, raising result
// valid. Configuration writes are accepted every clock; write them only
// while no frame is in flight. Unknown register index writes are dropped.
module ymodem_frame_receiver import ymfr_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = 2048
) (
  input wire logic   clk,
  input wire logic   rst,
  ymfr_in_if.sink    item,
  ymfr_out_if.source result,
  ymfr_cfg_if.sink   cfg
);

  logic [31:0] app_base_address;
  logic [7:0]  erase_sector_count;
  logic [15:0] idle_timeout_ticks;
  logic [7:0]  end_response_byte;

  ymfr_cfg_t   back_cfg;
  ymfr_frame_t frame;
  ymfr_qstat_t qstat;
  logic        pop;

  // Always take configuration transfers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      app_base_address   <= 32'h0801_0000;
      erase_sector_count <= 8'd8;
      idle_timeout_ticks <= 16'd10;
      end_response_byte  <= 8'h4F;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_APP_BASE:  app_base_address   <= cfg.wdata;
        REG_ERASE_CNT: erase_sector_count <= cfg.wdata[7:0];
        REG_TIMEOUT:   idle_timeout_ticks <= cfg.wdata[15:0];
        REG_END_BYTE:  end_response_byte  <= cfg.wdata[7:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.app_base_address   = app_base_address;
  assign back_cfg.erase_sector_count = erase_sector_count;
  assign back_cfg.end_response_byte  = end_response_byte;

  // Front end: frame assembly and gap timer
  ymfr_front #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .item               (item),
    .idle_timeout_ticks (idle_timeout_ticks),
    .qstat              (qstat),
    .frame              (frame)
  );

  // Closed-frame queue
  ymfr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .pop   (pop),
    .qstat (qstat)
  );

  // Back end: protocol phases and result sequencing
  ymfr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (back_cfg),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire
